>>> rtl/zsv_pkg.sv
package zsv_pkg;

  localparam int unsigned MAX_ELEMS_DEF = 64;
  localparam int unsigned VALUE_W       = 32;

  // One input transfer.
  typedef struct packed {
    logic signed [VALUE_W-1:0] in_value;
    logic                      in_last;
  } zsv_in_t;

  // One result transfer.
  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
  } zsv_out_t;

  // A new element travelling down the chain looking for matches and a free slot.
  // Once it has found its slot it keeps moving as a dead marker, so that the end
  // of the chain can tell when the final element of a set has settled.
  typedef struct packed {
    logic                      live;
    logic                      last;
    logic                      hit;
    logic signed [VALUE_W-1:0] value;
  } zsv_probe_t;

  // Contents of one cell. dup is set once the value has been seen twice.
  typedef struct packed {
    logic                      occ;
    logic                      dup;
    logic signed [VALUE_W-1:0] value;
  } zsv_entry_t;

  // Controls shared by every cell.
  typedef struct packed {
    logic shift_en;
  } zsv_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_EMIT  = 3'b100
  } zsv_state_t;

endpackage

>>> rtl/zsv_cell.sv
module zsv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  zsv_pkg::zsv_ctrl_t ctrl,
  input  zsv_pkg::zsv_probe_t probe_in,
  output zsv_pkg::zsv_probe_t probe_out,
  input  zsv_pkg::zsv_entry_t entry_in,
  output zsv_pkg::zsv_entry_t entry_out
);

  zsv_pkg::zsv_entry_t entry_r;
  zsv_pkg::zsv_entry_t entry_nxt;
  zsv_pkg::zsv_probe_t probe_r;
  zsv_pkg::zsv_probe_t probe_nxt;
  logic                match;

  assign match = entry_r.occ && (entry_r.value == probe_in.value);

  always_comb begin
    entry_nxt = entry_r;
    probe_nxt = probe_in;
    if (ctrl.shift_en) begin
      // Unload toward the head: take the neighbor's contents.
      entry_nxt = entry_in;
      probe_nxt.live = 1'b0;
      probe_nxt.last = 1'b0;
    end else if (probe_in.live) begin
      if (entry_r.occ) begin
        entry_nxt.dup = entry_r.dup | match;
        probe_nxt.hit = probe_in.hit | match;
      end else begin
        // First free slot: the element settles here.
        entry_nxt.occ   = 1'b1;
        entry_nxt.dup   = probe_in.hit;
        entry_nxt.value = probe_in.value;
        probe_nxt.live  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.occ  <= 1'b0;
      entry_r.dup  <= 1'b0;
      probe_r.live <= 1'b0;
      probe_r.last <= 1'b0;
    end else begin
      entry_r.occ  <= entry_nxt.occ;
      entry_r.dup  <= entry_nxt.dup;
      probe_r.live <= probe_nxt.live;
      probe_r.last <= probe_nxt.last;
    end
    entry_r.value <= entry_nxt.value;
    probe_r.hit   <= probe_nxt.hit;
    probe_r.value <= probe_nxt.value;
  end

  assign probe_out = probe_r;
  assign entry_out = entry_r;

endmodule

>>> rtl/zero_singleton_values.sv
// zero_singleton_values
//
// The input channel (in_valid, in_stall, in_data) takes one signed 32-bit
// value per transfer; in_last marks the final value of a set. The block keeps
// up to MAX_ELEMS values; further values of an oversized set are dropped.
// Once the set is complete, the output channel (out_valid, out_stall,
// out_data) returns one transfer per stored value in arrival order: the value
// itself if it occurs two or more times among the stored values, 0 if it
// occurs only once. The final result carries out_last.
//
// Values are taken one per cycle while the block is loading. Each value walks
// the row of cells one cell per cycle, so after the last transfer of a set the
// input is stalled while it reaches the end of the row, and then while the row
// unloads through the output register.
//
// A stall on the output holds the output register and freezes the unload; no
// result is lost. Reset clears every cell and returns the block to loading.
module zero_singleton_values #(
  parameter int unsigned MAX_ELEMS = zsv_pkg::MAX_ELEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  zsv_pkg::zsv_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output zsv_pkg::zsv_out_t out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1);

  zsv_pkg::zsv_state_t state_r;
  zsv_pkg::zsv_state_t state_nxt;

  // probes[k] enters cell k; entries[k] is the contents of cell k.
  // Both arrays carry one spare slot at the tail end of the row.
  zsv_pkg::zsv_probe_t probes  [MAX_ELEMS+1];
  zsv_pkg::zsv_entry_t entries [MAX_ELEMS+1];
  zsv_pkg::zsv_ctrl_t  ctrl;
  zsv_pkg::zsv_probe_t tail;

  logic              in_accept;
  logic              out_free;
  logic              out_valid_r;
  logic              out_valid_nxt;
  zsv_pkg::zsv_out_t out_data_r;
  zsv_pkg::zsv_out_t out_data_nxt;

  // Values of the current set that have entered the row so far.
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              store_full;

  assign in_stall   = (state_r != zsv_pkg::ST_LOAD);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign tail       = probes[MAX_ELEMS];
  assign store_full = (count_r == CNT_W'(MAX_ELEMS));

  // A new value enters the head of the row in the cycle it is transferred.
  // Once the row is full, further values only carry the end-of-set marker, so
  // they neither take a slot nor mark any stored value as repeated.
  assign probes[0].live  = in_accept && !store_full;
  assign probes[0].last  = in_accept && in_data.in_last;
  assign probes[0].hit   = 1'b0;
  assign probes[0].value = in_data.in_value;

  // Nothing shifts in behind the tail cell while unloading.
  assign entries[MAX_ELEMS] = '0;

  always_comb begin
    count_nxt = count_r;
    if (in_accept) begin
      if (in_data.in_last) begin
        count_nxt = '0;
      end else if (!store_full) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // Unload one cell per cycle whenever the output register can take it.
  assign ctrl.shift_en = (state_r == zsv_pkg::ST_EMIT) && entries[0].occ && out_free;

  for (genvar k = 0; k < MAX_ELEMS; k++) begin : g_cell
    zsv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .probe_in  (probes[k]),
      .probe_out (probes[k+1]),
      .entry_in  (entries[k+1]),
      .entry_out (entries[k])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zsv_pkg::ST_LOAD: begin
        if (in_accept && in_data.in_last) begin
          state_nxt = zsv_pkg::ST_DRAIN;
        end
      end
      zsv_pkg::ST_DRAIN: begin
        // The final value has settled once its marker leaves the row.
        if (tail.last) begin
          state_nxt = zsv_pkg::ST_EMIT;
        end
      end
      zsv_pkg::ST_EMIT: begin
        if (!entries[0].occ) begin
          state_nxt = zsv_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = zsv_pkg::ST_LOAD;
      end
    endcase
  end

  // Output register: loaded from the head cell on each unload step.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctrl.shift_en) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_value = entries[0].dup ? entries[0].value : '0;
      // The head cell is the last one when nothing follows it.
      out_data_nxt.out_last  = (MAX_ELEMS == 1) ? 1'b1 : !entries[1].occ;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zsv_pkg::ST_LOAD;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result is only ever produced by an unload step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == zsv_pkg::ST_EMIT))
    else $error("result appeared outside the unload phase");

  // Every complete set leaves at least one value at the head of the row.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zsv_pkg::ST_DRAIN && tail.last) |=> entries[0].occ)
    else $error("unload started with an empty row");

  // No value may still be walking the row while it unloads.
  a_no_probe_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zsv_pkg::ST_EMIT) |-> (!tail.live && !tail.last && !probes[0].live))
    else $error("value in flight during unload");

  // The unload never shifts into a held output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ctrl.shift_en)
    else $error("unload step while result is stalled");

endmodule

>>> tb/testbench.sv
module testbench;

  // The store depth of the block under test. The predictor and the set
  // lengths below both follow it.
  localparam int MAX_ELEMS    = zsv_pkg::MAX_ELEMS_DEF;
  localparam int VALUE_W      = zsv_pkg::VALUE_W;
  localparam int RANDOM_ITEMS = 320;

  // Each set walks the row and unloads before the block takes the next value.
  // Even if every item were its own set and each transfer saw the longest gap
  // on both sides, the run stays far below this limit.
  localparam int CYCLE_LIMIT  = 400000;

  // How long the bench keeps watching for extra results once every owed result
  // has arrived.
  localparam int SETTLE_CYCLES = 2 * MAX_ELEMS + 16;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  zsv_pkg::zsv_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  zsv_pkg::zsv_out_t out_data;

  zero_singleton_values #(
    .MAX_ELEMS(MAX_ELEMS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the values of the set collected so far and, for each one,
  // whether it has been matched by any other value of the set. Only the first
  // MAX_ELEMS values of a set are kept; later ones are dropped and take no
  // part in matching.
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] held_values [MAX_ELEMS];
  bit                        held_dup    [MAX_ELEMS];
  int                        held_count;

  // Results that the block still owes, oldest first.
  zsv_pkg::zsv_out_t expected_results[$];

  int mismatch_count;
  int results_checked;
  int items_sent;
  int sets_sent;
  int oversize_sets;
  int cycle_count = 0;

  // Percentages of cycles in which each side holds back.
  int send_idle_pct;
  int recv_idle_pct;

  // Adds one value to the set. A match marks both the new value and every
  // earlier copy, so a value seen three or more times behaves like a pair.
  function automatic void absorb_value(input logic signed [VALUE_W-1:0] value);
    bit hit;
    hit = 1'b0;
    if (held_count >= MAX_ELEMS) return;
    for (int i = 0; i < held_count; i++) begin
      if (held_values[i] == value) begin
        held_dup[i] = 1'b1;
        hit         = 1'b1;
      end
    end
    held_values[held_count] = value;
    held_dup[held_count]    = hit;
    held_count++;
  endfunction

  // Closes the set: singletons read as zero, the final kept value carries the
  // last mark even when the item that closed the set was itself dropped.
  function automatic void close_set(input bit push_predicted);
    zsv_pkg::zsv_out_t res;
    if (push_predicted) begin
      for (int i = 0; i < held_count; i++) begin
        res.out_value = held_dup[i] ? held_values[i] : '0;
        res.out_last  = (i == held_count - 1);
        expected_results.push_back(res);
      end
    end
    held_count = 0;
    for (int i = 0; i < MAX_ELEMS; i++) held_dup[i] = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. The item is presented at a clock edge and held until an edge
  // at which the block does not stall. in_valid is only lowered when a gap is
  // actually taken, so it never sees two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input zsv_pkg::zsv_in_t item, input bit push_predicted);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    // The transfer has happened at this edge.
    items_sent++;
    absorb_value(item.in_value);
    if (item.in_last) close_set(push_predicted);
  endtask

  // Sender holds back until the block has handed over everything it owes.
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random 32-bit patterns half of the time, with the extremes and a few small values
  // mixed in so that they turn up both alone and in pairs.
  function automatic logic signed [VALUE_W-1:0] fresh_value();
    case ($urandom_range(9))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return VALUE_W'($urandom_range(7)) - VALUE_W'(3);
      default: return $urandom;
    endcase
  endfunction

  // One well-formed set with random content. Values are often reused from
  // earlier in the same set so that pairs, triples and singletons all occur.
  task automatic send_random_set(input int len);
    logic signed [VALUE_W-1:0] pool[$];
    zsv_pkg::zsv_in_t item;
    for (int k = 0; k < len; k++) begin
      if (pool.size() != 0 && $urandom_range(99) < 45) begin
        item.in_value = pool[$urandom_range(pool.size() - 1)];
      end else begin
        item.in_value = fresh_value();
        pool.push_back(item.in_value);
      end
      item.in_last = (k == len - 1);
      send_item(item, 1'b1);
    end
    sets_sent++;
    if (len > MAX_ELEMS) oversize_sets++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed stimulus. Each row is one input transfer. Where the results of a
  // closing row are obvious they are typed in; other rows rely on the
  // predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    zsv_pkg::zsv_in_t  item;
    int                n_typed;   // negative: results come from the predictor
    zsv_pkg::zsv_out_t typed[4];
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(input logic signed [VALUE_W-1:0] value,
                                  input logic last);
    stim_row_t row;
    row.item.in_value = value;
    row.item.in_last  = last;
    row.n_typed       = -1;
    directed_rows.push_back(row);
  endfunction

  // Attaches one typed result to the most recent row.
  function automatic void add_typed(input logic signed [VALUE_W-1:0] value,
                                    input logic last);
    stim_row_t row;
    row = directed_rows.pop_back();
    if (row.n_typed < 0) row.n_typed = 0;
    row.typed[row.n_typed].out_value = value;
    row.typed[row.n_typed].out_last  = last;
    row.n_typed++;
    directed_rows.push_back(row);
  endfunction

  task automatic build_directed();
    // A set of one value: it can only be a singleton.
    add_row(32'sh7FFF_FFFF, 1'b1);
    add_typed(32'sh0, 1'b1);
    // The most negative value as a pair.
    add_row(32'sh8000_0000, 1'b0);
    add_row(32'sh8000_0000, 1'b1);
    add_typed(32'sh8000_0000, 1'b0);
    add_typed(32'sh8000_0000, 1'b1);
    // Pairs interleaved with singletons, zero among them.
    add_row(32'sh5, 1'b0);
    add_row(-32'sh1, 1'b0);
    add_row(32'sh5, 1'b0);
    add_row(32'sh0, 1'b0);
    add_row(-32'sh1, 1'b0);
    add_row(32'sh7, 1'b1);
    // The same value three times: all copies are marked as repeated and stay.
    add_row(32'sh3, 1'b0);
    add_row(32'sh3, 1'b0);
    add_row(32'sh3, 1'b1);
    // Zero as a pair looks the same as two singletons, but must still pass.
    add_row(32'sh0, 1'b0);
    add_row(32'sh0, 1'b1);
    // Every value differs: every result is zero.
    add_row(32'shFFFF_FFFF, 1'b0);
    add_row(32'sh7FFF_FFFF, 1'b0);
    add_row(32'sh8000_0000, 1'b0);
    add_row(32'sh1, 1'b1);
    add_typed(32'sh0, 1'b0);
    add_typed(32'sh0, 1'b0);
    add_typed(32'sh0, 1'b0);
    add_typed(32'sh0, 1'b1);
    // Values that differ in one bit only must not match; the first value also returns as a pair.
    add_row(32'sh5555_AAAA, 1'b0);
    add_row(32'sh5555_AAAB, 1'b0);
    add_row(32'shD555_AAAA, 1'b0);
    add_row(32'sh5555_AAAA, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Output side. The stall is redrawn every cycle; a transfer is taken from the
  // values seen at the edge, before this block's own update lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    zsv_pkg::zsv_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: value %0d last %0b",
                 $time, out_data.out_value, out_data.out_last);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.out_value !== want.out_value) begin
          $display("%0t: out_value expected %0d (0x%08h), got %0d (0x%08h)",
                   $time, want.out_value, want.out_value,
                   out_data.out_value, out_data.out_value);
          mismatch_count++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t: out_last expected %0b, got %0b",
                   $time, want.out_last, out_data.out_last);
          mismatch_count++;
        end
      end
    end
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not complete, %0d results still owed",
               $time, expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int set_num;
    int len;
    int phase;
    int cur_phase;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    mismatch_count  = 0;
    results_checked = 0;
    items_sent      = 0;
    sets_sent       = 0;
    oversize_sets   = 0;
    held_count      = 0;
    send_idle_pct   = 26;
    recv_idle_pct   = 48;
    for (int i = 0; i < MAX_ELEMS; i++) held_dup[i] = 1'b0;

    build_directed();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows first, under the first idling pattern.
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].n_typed < 0);
      for (int k = 0; k < directed_rows[r].n_typed; k++)
        expected_results.push_back(directed_rows[r].typed[k]);
      if (directed_rows[r].item.in_last) sets_sent++;
    end

    // Random sets. The idling pattern changes by thirds of the random items;
    // at each change the sender waits for the block to empty completely.
    items_sent = 0;
    set_num    = 0;
    cur_phase  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase = (items_sent * 3) / RANDOM_ITEMS;
      if (phase != cur_phase) begin
        cur_phase = phase;
        drain_pause();
        case (cur_phase)
          1: begin
            send_idle_pct = 48;
            recv_idle_pct = 26;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
      end
      // Fixed boundary cases: a set that exactly fills the store, and a set
      // whose tail, including the closing item, is dropped.
      if (set_num == 3)       len = MAX_ELEMS;
      else if (set_num == 7)  len = MAX_ELEMS + 3;
      else if ($urandom_range(99) < 4) len = $urandom_range(MAX_ELEMS + 4, MAX_ELEMS - 1);
      else                    len = $urandom_range(12, 1);
      send_random_set(len);
      set_num++;
    end
    in_valid <= 1'b0;

    // Let every owed result arrive, then watch a while longer for extras.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) mismatch_count++;

    $display("Ran %0d directed rows and %0d random items in %0d sets in all,",
             directed_rows.size(), items_sent, sets_sent);
    $display("%0d random sets overflowing the store; %0d results checked.",
             oversize_sets, results_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
